// ----- rtl/qnsf_pkg.sv -----
// ----------------------------------------------------------------------------
// qnsf_pkg
// Shared types, constants and decode tables for the second-order node basis
// evaluator.
// ----------------------------------------------------------------------------
package qnsf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CW = 18;  // coordinate width
   localparam int OW = 18;  // result width
   localparam int AW = 21;  // axis factor / simplex operand width
   localparam int PW = 24;  // product width carried down the pipe

   localparam logic signed [AW-1:0] ONE_FX = AW'(1) << FRAC_BITS;
   localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

   typedef enum logic [1:0] {
      AX_LO   = 2'd0,
      AX_MID  = 2'd1,
      AX_HI   = 2'd2,
      AX_NONE = 2'd3
   } axis_code_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_NUMBER  = 3'd1,
      ST_NOT_READY   = 3'd2,
      ST_KIND_DENIED = 3'd3,
      ST_UNKNOWN     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ET_LINE  = 3'd0,
      ET_TRI   = 3'd1,
      ET_QUAD  = 3'd2,
      ET_TET   = 3'd3,
      ET_HEX   = 3'd4,
      ET_PRISM = 3'd5,
      ET_PYR   = 3'd6,
      ET_UNK   = 3'd7
   } elem_type;

   typedef enum logic [1:0] {
      EK_EDGE   = 2'd0,
      EK_FACE   = 2'd1,
      EK_VOLUME = 2'd2,
      EK_BAD    = 2'd3
   } kind_type;

   // simplex edge pairs: l*u, l*v, l*w, u*v, u*w, v*w
   typedef enum logic [2:0] {
      SX_LU = 3'd0,
      SX_LV = 3'd1,
      SX_LW = 3'd2,
      SX_UV = 3'd3,
      SX_UW = 3'd4,
      SX_VW = 3'd5
   } simplex_sel_type;

   typedef struct packed {
      status_type      status;
      logic            simplex;
      logic            is_tri;
      simplex_sel_type sel;
      axis_code_type   code_w;
      axis_code_type   code_v;
      axis_code_type   code_u;
   } decode_type;

   function automatic decode_type mk_tensor(axis_code_type cu, axis_code_type cv,
                                            axis_code_type cw);
      decode_type d;
      d.status  = ST_OK;
      d.simplex = 1'b0;
      d.is_tri  = 1'b0;
      d.sel     = SX_LU;
      d.code_u  = cu;
      d.code_v  = cv;
      d.code_w  = cw;
      return d;
   endfunction

   function automatic decode_type mk_simplex(simplex_sel_type s, logic is_tri);
      decode_type d;
      d = mk_tensor(AX_NONE, AX_NONE, AX_NONE);
      d.simplex = 1'b1;
      d.is_tri  = is_tri;
      d.sel     = s;
      return d;
   endfunction

   function automatic decode_type mk_status(status_type st);
      decode_type d;
      d = mk_tensor(AX_NONE, AX_NONE, AX_NONE);
      d.status = st;
      return d;
   endfunction

   function automatic decode_type quad_edge(logic [3:0] num);
      decode_type d;
      case (num)
         4'd1:    d = mk_tensor(AX_MID, AX_LO,  AX_NONE);
         4'd2:    d = mk_tensor(AX_LO,  AX_MID, AX_NONE);
         4'd3:    d = mk_tensor(AX_HI,  AX_MID, AX_NONE);
         4'd4:    d = mk_tensor(AX_MID, AX_HI,  AX_NONE);
         default: d = mk_status(ST_BAD_NUMBER);
      endcase
      return d;
   endfunction

   function automatic decode_type hex_edge(logic [3:0] num);
      decode_type d;
      case (num)
         4'd1:    d = mk_tensor(AX_MID, AX_LO,  AX_LO);
         4'd2:    d = mk_tensor(AX_LO,  AX_MID, AX_LO);
         4'd3:    d = mk_tensor(AX_LO,  AX_LO,  AX_MID);
         4'd4:    d = mk_tensor(AX_HI,  AX_MID, AX_LO);
         4'd5:    d = mk_tensor(AX_HI,  AX_LO,  AX_MID);
         4'd6:    d = mk_tensor(AX_MID, AX_HI,  AX_LO);
         4'd7:    d = mk_tensor(AX_HI,  AX_HI,  AX_MID);
         4'd8:    d = mk_tensor(AX_LO,  AX_HI,  AX_MID);
         4'd9:    d = mk_tensor(AX_MID, AX_LO,  AX_HI);
         4'd10:   d = mk_tensor(AX_LO,  AX_MID, AX_HI);
         4'd11:   d = mk_tensor(AX_HI,  AX_MID, AX_HI);
         4'd12:   d = mk_tensor(AX_MID, AX_HI,  AX_HI);
         default: d = mk_status(ST_BAD_NUMBER);
      endcase
      return d;
   endfunction

   function automatic decode_type hex_face(logic [3:0] num);
      decode_type d;
      case (num)
         4'd1:    d = mk_tensor(AX_MID, AX_LO,  AX_MID);
         4'd2:    d = mk_tensor(AX_MID, AX_MID, AX_LO);
         4'd3:    d = mk_tensor(AX_LO,  AX_MID, AX_MID);
         4'd4:    d = mk_tensor(AX_HI,  AX_MID, AX_MID);
         4'd5:    d = mk_tensor(AX_MID, AX_HI,  AX_MID);
         4'd6:    d = mk_tensor(AX_MID, AX_MID, AX_HI);
         default: d = mk_status(ST_BAD_NUMBER);
      endcase
      return d;
   endfunction

   function automatic decode_type tet_edge(logic [3:0] num);
      decode_type d;
      case (num)
         4'd1:    d = mk_simplex(SX_LU, 1'b0);
         4'd2:    d = mk_simplex(SX_LV, 1'b0);
         4'd3:    d = mk_simplex(SX_LW, 1'b0);
         4'd4:    d = mk_simplex(SX_UV, 1'b0);
         4'd5:    d = mk_simplex(SX_UW, 1'b0);
         4'd6:    d = mk_simplex(SX_VW, 1'b0);
         default: d = mk_status(ST_BAD_NUMBER);
      endcase
      return d;
   endfunction

   function automatic decode_type tri_edge(logic [3:0] num);
      decode_type d;
      case (num)
         4'd1:    d = mk_simplex(SX_LU, 1'b1);
         4'd2:    d = mk_simplex(SX_LV, 1'b1);
         4'd3:    d = mk_simplex(SX_UV, 1'b1);
         default: d = mk_status(ST_BAD_NUMBER);
      endcase
      return d;
   endfunction

   function automatic decode_type decode(logic [2:0] et, logic [1:0] ek, logic [3:0] num);
      decode_type d;
      if (elem_type'(et) == ET_UNK) begin
         d = mk_status(ST_UNKNOWN);
      end else begin
         case (kind_type'(ek))
            EK_EDGE: begin
               case (elem_type'(et))
                  ET_LINE: d = (num == 4'd1) ? mk_tensor(AX_MID, AX_NONE, AX_NONE)
                                             : mk_status(ST_BAD_NUMBER);
                  ET_TRI:  d = tri_edge(num);
                  ET_QUAD: d = quad_edge(num);
                  ET_TET:  d = tet_edge(num);
                  ET_HEX:  d = hex_edge(num);
                  default: d = mk_status(ST_NOT_READY);
               endcase
            end
            EK_FACE: begin
               if (elem_type'(et) == ET_HEX)
                  d = hex_face(num);
               else if (elem_type'(et) inside {ET_QUAD, ET_PRISM, ET_PYR})
                  d = mk_status(ST_NOT_READY);
               else
                  d = mk_status(ST_KIND_DENIED);
            end
            EK_VOLUME: begin
               d = (elem_type'(et) == ET_HEX) ? mk_tensor(AX_MID, AX_MID, AX_MID)
                                              : mk_status(ST_KIND_DENIED);
            end
            default: d = mk_status(ST_KIND_DENIED);
         endcase
      end
      return d;
   endfunction

   // round half up to FRAC_BITS, keep PW bits
   function automatic logic signed [PW-1:0] rnd_frac(logic signed [47:0] p);
      logic signed [47:0] q;
      q = (p + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return q[PW-1:0];
   endfunction

   function automatic logic signed [OW-1:0] sat_out(logic signed [PW-1:0] x);
      logic signed [OW-1:0] r;
      if (x > PW'(OUT_MAX))
         r = OUT_MAX;
      else if (x < PW'(OUT_MIN))
         r = OUT_MIN;
      else
         r = x[OW-1:0];
      return r;
   endfunction

endpackage

// ----- rtl/qnsf_req_if.sv -----
// ----------------------------------------------------------------------------
// qnsf_req_if
// Request channel: element selection and reference coordinates.
// ----------------------------------------------------------------------------
interface qnsf_req_if
   import qnsf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [2:0]           element_type;
   logic [1:0]           entity_kind;
   logic [3:0]           entity_number;
   logic signed [CW-1:0] coord_u;
   logic signed [CW-1:0] coord_v;
   logic signed [CW-1:0] coord_w;

   modport source (output valid, element_type, entity_kind, entity_number,
                   coord_u, coord_v, coord_w, input ready);
   modport sink   (input valid, element_type, entity_kind, entity_number,
                   coord_u, coord_v, coord_w, output ready);
endinterface

// ----- rtl/qnsf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// qnsf_rsp_if
// Response channel: basis value, reference gradient and status.
// ----------------------------------------------------------------------------
interface qnsf_rsp_if
   import qnsf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic signed [OW-1:0] basis_value;
   logic signed [OW-1:0] grad_u;
   logic signed [OW-1:0] grad_v;
   logic signed [OW-1:0] grad_w;
   logic [2:0]           status;

   modport source (output valid, basis_value, grad_u, grad_v, grad_w, status,
                   input ready);
   modport sink   (input valid, basis_value, grad_u, grad_v, grad_w, status,
                   output ready);
endinterface

// ----- rtl/quadratic_node_shape_function_eval_top.sv -----
// ----------------------------------------------------------------------------
// quadratic_node_shape_function_eval_top
// Second-order hierarchical node basis evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one evaluation per beat: element type, entity kind,
//   one-based entity number and reference coordinates u, v, w (Q.16).
//   rsp_bus returns one beat per request, in order: basis value, gradient
//   along u, v, w (Q.16, saturated to 18 bits) and a status code. Any
//   non-ok status returns zeros in all numeric fields.
//   Throughput is one beat per cycle while rsp_bus is not stalled; a beat
//   passes through four register stages (axis factors, first tensor
//   product, second tensor product, saturation/output), each holding at
//   most one 21x21 or 24x21 multiply per lane.
//   Each stage advances when it is empty or the one after it advances, so
//   bubbles collapse; a stalled rsp_bus holds the output register and the
//   stages behind it fill up before req_bus.ready drops. Nothing is lost or
//   repeated across a stall.
//   Synchronous reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_node_shape_function_eval_top
   import qnsf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   qnsf_req_if.sink   req_bus,
   qnsf_rsp_if.source rsp_bus
);

   // ---------------- stage enables ----------------
   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en4 = !v4_ff || rsp_bus.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1;

   // ---------------- stage 1: decode, axis factors, simplex ----------------
   decode_type           dec;
   logic signed [CW-1:0] w_eff;
   logic signed [AW-1:0] f_u, f_v, f_w, d_u, d_v, d_w;
   logic signed [AW-1:0] ue, ve, we, lam;
   logic signed [AW-1:0] sa, sb;
   logic signed [PW-1:0] sg_u, sg_v, sg_w;
   logic signed [47:0]   sprod;

   assign dec   = decode(req_bus.element_type, req_bus.entity_kind, req_bus.entity_number);
   assign w_eff = dec.is_tri ? '0 : req_bus.coord_w;

   qnsf_axis u_ax_u (.code(dec.code_u), .x(req_bus.coord_u), .f(f_u), .d(d_u));
   qnsf_axis u_ax_v (.code(dec.code_v), .x(req_bus.coord_v), .f(f_v), .d(d_v));
   qnsf_axis u_ax_w (.code(dec.code_w), .x(req_bus.coord_w), .f(f_w), .d(d_w));

   assign ue  = AW'(req_bus.coord_u);
   assign ve  = AW'(req_bus.coord_v);
   assign we  = AW'(w_eff);
   assign lam = ONE_FX - ue - ve - we;

   always_comb begin
      case (dec.sel)
         SX_LU: begin
            sa = lam; sb = ue;
            sg_u = PW'(lam - ue); sg_v = -PW'(ue); sg_w = -PW'(ue);
         end
         SX_LV: begin
            sa = lam; sb = ve;
            sg_u = -PW'(ve); sg_v = PW'(lam - ve); sg_w = -PW'(ve);
         end
         SX_LW: begin
            sa = lam; sb = we;
            sg_u = -PW'(we); sg_v = -PW'(we); sg_w = PW'(lam - we);
         end
         SX_UV: begin
            sa = ue; sb = ve;
            sg_u = PW'(ve); sg_v = PW'(ue); sg_w = '0;
         end
         SX_UW: begin
            sa = ue; sb = we;
            sg_u = PW'(we); sg_v = '0; sg_w = PW'(ue);
         end
         default: begin
            sa = ve; sb = we;
            sg_u = '0; sg_v = PW'(we); sg_w = PW'(ve);
         end
      endcase
   end

   assign sprod = 48'(sa * sb);

   status_type           st1_ff;
   logic                 sx1_ff;
   logic signed [AW-1:0] f0_1_ff, f1_1_ff, f2_1_ff, d0_1_ff, d1_1_ff, d2_1_ff;
   logic signed [PW-1:0] s0_1_ff, s1_1_ff, s2_1_ff, s3_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_bus.valid;
      end
      if (en1) begin
         st1_ff  <= dec.status;
         sx1_ff  <= dec.simplex;
         f0_1_ff <= f_u;
         f1_1_ff <= f_v;
         f2_1_ff <= f_w;
         d0_1_ff <= d_u;
         d1_1_ff <= d_v;
         d2_1_ff <= d_w;
         s0_1_ff <= rnd_frac(sprod);
         s1_1_ff <= sg_u;
         s2_1_ff <= sg_v;
         s3_1_ff <= dec.is_tri ? '0 : sg_w;
      end
   end

   // ---------------- stage 2: u-by-v products ----------------
   logic signed [47:0]   p_ff2_a, p_ff2_b, p_ff2_c;
   status_type           st2_ff;
   logic                 sx2_ff;
   logic signed [PW-1:0] a2_ff, b2_ff, c2_ff;
   logic signed [AW-1:0] f2_2_ff, d2_2_ff;
   logic signed [PW-1:0] s0_2_ff, s1_2_ff, s2_2_ff, s3_2_ff;

   assign p_ff2_a = 48'(f0_1_ff * f1_1_ff);
   assign p_ff2_b = 48'(d0_1_ff * f1_1_ff);
   assign p_ff2_c = 48'(f0_1_ff * d1_1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         st2_ff  <= st1_ff;
         sx2_ff  <= sx1_ff;
         a2_ff   <= rnd_frac(p_ff2_a);
         b2_ff   <= rnd_frac(p_ff2_b);
         c2_ff   <= rnd_frac(p_ff2_c);
         f2_2_ff <= f2_1_ff;
         d2_2_ff <= d2_1_ff;
         s0_2_ff <= s0_1_ff;
         s1_2_ff <= s1_1_ff;
         s2_2_ff <= s2_1_ff;
         s3_2_ff <= s3_1_ff;
      end
   end

   // ---------------- stage 3: times w factor ----------------
   logic signed [47:0]   q_val, q_gu, q_gv, q_gw;
   status_type           st3_ff;
   logic signed [PW-1:0] r0_3_ff, r1_3_ff, r2_3_ff, r3_3_ff;

   assign q_val = 48'(a2_ff * f2_2_ff);
   assign q_gu  = 48'(b2_ff * f2_2_ff);
   assign q_gv  = 48'(c2_ff * f2_2_ff);
   assign q_gw  = 48'(a2_ff * d2_2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         st3_ff  <= st2_ff;
         r0_3_ff <= sx2_ff ? s0_2_ff : rnd_frac(q_val);
         r1_3_ff <= sx2_ff ? s1_2_ff : rnd_frac(q_gu);
         r2_3_ff <= sx2_ff ? s2_2_ff : rnd_frac(q_gv);
         r3_3_ff <= sx2_ff ? s3_2_ff : rnd_frac(q_gw);
      end
   end

   // ---------------- stage 4: saturate, output register ----------------
   logic                 ok3;
   status_type           st4_ff;
   logic signed [OW-1:0] o0_ff, o1_ff, o2_ff, o3_ff;

   assign ok3 = (st3_ff == ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         st4_ff <= st3_ff;
         o0_ff  <= ok3 ? sat_out(r0_3_ff) : '0;
         o1_ff  <= ok3 ? sat_out(r1_3_ff) : '0;
         o2_ff  <= ok3 ? sat_out(r2_3_ff) : '0;
         o3_ff  <= ok3 ? sat_out(r3_3_ff) : '0;
      end
   end

   assign rsp_bus.valid       = v4_ff;
   assign rsp_bus.basis_value = o0_ff;
   assign rsp_bus.grad_u      = o1_ff;
   assign rsp_bus.grad_v      = o2_ff;
   assign rsp_bus.grad_w      = o3_ff;
   assign rsp_bus.status      = st4_ff;

   // ---------------- assertions ----------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      v4_ff && st4_ff != ST_OK |->
         o0_ff == '0 && o1_ff == '0 && o2_ff == '0 && o3_ff == '0)
      else $error("non-ok status with nonzero result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff && !v4_ff)
      else $error("pipeline not empty after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> v1_ff && v2_ff && v3_ff && v4_ff)
      else $error("request stalled with a bubble in the pipe");

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !en4 |=> v3_ff && $stable(r0_3_ff) && $stable(st3_ff))
      else $error("stage 3 changed while blocked");

endmodule

// ----- rtl/qnsf_axis.sv -----
// ----------------------------------------------------------------------------
// qnsf_axis
// One-axis quadratic factor (m*m/4, m*p/4 or p*p/4) and its derivative.
// ----------------------------------------------------------------------------
module qnsf_axis
   import qnsf_pkg::*;
(
   input  axis_code_type        code,
   input  logic signed [CW-1:0] x,
   output logic signed [AW-1:0] f,
   output logic signed [AW-1:0] d
);

   localparam logic signed [2*AW-1:0] HALF_AX = (2*AW)'(1) << (FRAC_BITS + 1);

   logic signed [AW-1:0]   xe;
   logic signed [AW-1:0]   m;
   logic signed [AW-1:0]   p;
   logic signed [AW-1:0]   op_a;
   logic signed [AW-1:0]   op_b;
   logic signed [AW-1:0]   dv;
   logic signed [2*AW-1:0] prod;
   logic signed [2*AW-1:0] fr;

   assign xe = AW'(x);
   assign m  = ONE_FX - xe;
   assign p  = ONE_FX + xe;

   always_comb begin
      case (code)
         AX_LO:   begin op_a = m; op_b = m; dv = -m;  end
         AX_MID:  begin op_a = m; op_b = p; dv = -xe; end
         AX_HI:   begin op_a = p; op_b = p; dv = p;   end
         default: begin op_a = m; op_b = p; dv = '0;  end
      endcase
   end

   assign prod = op_a * op_b;
   assign fr   = (prod + HALF_AX) >>> (FRAC_BITS + 2);

   always_comb begin
      if (code == AX_NONE) begin
         f = ONE_FX;
         d = '0;
      end else begin
         f = fr[AW-1:0];
         d = (dv + AW'(1)) >>> 1;
      end
   end

endmodule

// ----- verif/qnsf_scoreboard.sv -----
// ----------------------------------------------------------------------------
// qnsf_scoreboard
// Basis-value predictor and in-order checker for the second-order node basis
// evaluator. Each request beat is turned into an expected response; each
// response beat is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
package qnsf_scoreboard_pkg;
   import qnsf_pkg::*;

   typedef struct {
      logic signed [OW-1:0] basis_value;
      logic signed [OW-1:0] grad_u;
      logic signed [OW-1:0] grad_v;
      logic signed [OW-1:0] grad_w;
      status_type           status;
   } basis_result_type;

   localparam longint LIM = 64'sd2147483647;
   localparam longint ONE = 64'sd1 << FRAC_BITS;

   class basis_scoreboard;
      basis_result_type pending[$];
      int               mismatches;
      int               beats_checked;

      function longint clip(longint x, longint lo, longint hi);
         return x < lo ? lo : (x > hi ? hi : x);
      endfunction

      // round half up, then floor
      function longint round_shift(longint p, int s);
         longint q;
         q = p + (64'sd1 << (s - 1));
         return q >>> s;
      endfunction

      function longint qmul(longint a, longint b, int s);
         a = clip(a, -LIM, LIM);
         b = clip(b, -LIM, LIM);
         return clip(round_shift(a * b, s), -LIM, LIM);
      endfunction

      function void axis(axis_code_type c, longint x, output longint f,
                         output longint d);
         longint m, p;
         m = ONE - x;
         p = ONE + x;
         case (c)
            AX_LO:   begin f = qmul(m, m, FRAC_BITS + 2); d = round_shift(-m, 1); end
            AX_MID:  begin f = qmul(m, p, FRAC_BITS + 2); d = round_shift(-x, 1); end
            AX_HI:   begin f = qmul(p, p, FRAC_BITS + 2); d = round_shift(p, 1); end
            default: begin f = ONE; d = 0; end
         endcase
      endfunction

      function void tensor(axis_code_type cu, axis_code_type cv, axis_code_type cw,
                           longint x[3], ref longint r[4]);
         longint fu, du, fv, dv, fw, dw;
         axis(cu, x[0], fu, du);
         axis(cv, x[1], fv, dv);
         axis(cw, x[2], fw, dw);
         r[0] = qmul(qmul(fu, fv, FRAC_BITS), fw, FRAC_BITS);
         r[1] = qmul(qmul(du, fv, FRAC_BITS), fw, FRAC_BITS);
         r[2] = qmul(qmul(fu, dv, FRAC_BITS), fw, FRAC_BITS);
         r[3] = qmul(qmul(fu, fv, FRAC_BITS), dw, FRAC_BITS);
      endfunction

      // barycentric pair products; edge 1..6 of the tetrahedron
      function void simplex(int e, longint u, longint v, longint w, ref longint r[4]);
         longint l;
         l = ONE - u - v - w;
         case (e)
            1: begin r[0] = qmul(l, u, FRAC_BITS); r[1] = l - u; r[2] = -u; r[3] = -u; end
            2: begin r[0] = qmul(l, v, FRAC_BITS); r[1] = -v; r[2] = l - v; r[3] = -v; end
            3: begin r[0] = qmul(l, w, FRAC_BITS); r[1] = -w; r[2] = -w; r[3] = l - w; end
            4: begin r[0] = qmul(u, v, FRAC_BITS); r[1] = v; r[2] = u; r[3] = 0; end
            5: begin r[0] = qmul(u, w, FRAC_BITS); r[1] = w; r[2] = 0; r[3] = u; end
            default: begin r[0] = qmul(v, w, FRAC_BITS); r[1] = 0; r[2] = w; r[3] = v; end
         endcase
      endfunction

      function void note_request(elem_type et, kind_type ek, logic [3:0] num,
                                 logic signed [CW-1:0] cu, logic signed [CW-1:0] cv,
                                 logic signed [CW-1:0] cw);
         longint x[3];
         longint r[4];
         axis_code_type qe[4][2];
         axis_code_type he[12][3];
         axis_code_type hf[6][3];
         status_type st;
         basis_result_type res;
         int tri_pair[3];
         qe = '{'{AX_MID, AX_LO}, '{AX_LO, AX_MID}, '{AX_HI, AX_MID}, '{AX_MID, AX_HI}};
         he = '{'{AX_MID, AX_LO, AX_LO}, '{AX_LO, AX_MID, AX_LO}, '{AX_LO, AX_LO, AX_MID},
                '{AX_HI, AX_MID, AX_LO}, '{AX_HI, AX_LO, AX_MID}, '{AX_MID, AX_HI, AX_LO},
                '{AX_HI, AX_HI, AX_MID}, '{AX_LO, AX_HI, AX_MID}, '{AX_MID, AX_LO, AX_HI},
                '{AX_LO, AX_MID, AX_HI}, '{AX_HI, AX_MID, AX_HI}, '{AX_MID, AX_HI, AX_HI}};
         hf = '{'{AX_MID, AX_LO, AX_MID}, '{AX_MID, AX_MID, AX_LO}, '{AX_LO, AX_MID, AX_MID},
                '{AX_HI, AX_MID, AX_MID}, '{AX_MID, AX_HI, AX_MID}, '{AX_MID, AX_MID, AX_HI}};
         tri_pair = '{1, 2, 4};
         x[0] = cu;
         x[1] = cv;
         x[2] = cw;
         r = '{0, 0, 0, 0};
         st = ST_OK;
         if (et == ET_UNK) begin
            st = ST_UNKNOWN;
         end else if (ek == EK_EDGE) begin
            case (et)
               ET_LINE: if (num == 1) tensor(AX_MID, AX_NONE, AX_NONE, x, r);
                        else st = ST_BAD_NUMBER;
               ET_TRI: if (num >= 1 && num <= 3) begin
                     simplex(tri_pair[num - 1], x[0], x[1], 0, r);
                     r[3] = 0;
                  end else st = ST_BAD_NUMBER;
               ET_QUAD: if (num >= 1 && num <= 4)
                           tensor(qe[num - 1][0], qe[num - 1][1], AX_NONE, x, r);
                        else st = ST_BAD_NUMBER;
               ET_TET: if (num >= 1 && num <= 6) simplex(num, x[0], x[1], x[2], r);
                       else st = ST_BAD_NUMBER;
               ET_HEX: if (num >= 1 && num <= 12)
                          tensor(he[num - 1][0], he[num - 1][1], he[num - 1][2], x, r);
                       else st = ST_BAD_NUMBER;
               default: st = ST_NOT_READY;
            endcase
         end else if (ek == EK_FACE) begin
            if (et == ET_HEX) begin
               if (num >= 1 && num <= 6)
                  tensor(hf[num - 1][0], hf[num - 1][1], hf[num - 1][2], x, r);
               else st = ST_BAD_NUMBER;
            end else if (et == ET_QUAD || et == ET_PRISM || et == ET_PYR) begin
               st = ST_NOT_READY;
            end else begin
               st = ST_KIND_DENIED;
            end
         end else if (ek == EK_VOLUME && et == ET_HEX) begin
            tensor(AX_MID, AX_MID, AX_MID, x, r);
         end else begin
            st = ST_KIND_DENIED;
         end
         for (int i = 0; i < 4; i++)
            r[i] = (st != ST_OK) ? 0 : clip(r[i], -131072, 131071);
         res.basis_value = OW'(r[0]);
         res.grad_u      = OW'(r[1]);
         res.grad_v      = OW'(r[2]);
         res.grad_w      = OW'(r[3]);
         res.status      = st;
         pending.push_back(res);
      endfunction

      function void check_response(logic signed [OW-1:0] bv, logic signed [OW-1:0] gu,
                                   logic signed [OW-1:0] gv, logic signed [OW-1:0] gw,
                                   logic [2:0] st);
         basis_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response beat with nothing outstanding");
            return;
         end
         e = pending.pop_front();
         beats_checked++;
         if (bv !== e.basis_value || gu !== e.grad_u || gv !== e.grad_v ||
             gw !== e.grad_w || st !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR beat %0d: exp v=%0d gu=%0d gv=%0d gw=%0d st=%0d, ",
                         "got v=%0d gu=%0d gv=%0d gw=%0d st=%0d"},
                        beats_checked, e.basis_value, e.grad_u, e.grad_v, e.grad_w,
                        e.status, bv, gu, gv, gw, st);
         end
      endfunction
   endclass
endpackage

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives element/kind/entity selections with random and corner coordinates
// into the basis evaluator under random source gaps and sink stalls, and
// checks every response against the scoreboard's predicted values.
// ----------------------------------------------------------------------------
module tb;
   import qnsf_pkg::*;
   import qnsf_scoreboard_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   qnsf_req_if req_bus();
   qnsf_rsp_if rsp_bus();

   quadratic_node_shape_function_eval_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   basis_scoreboard sb = new();
   int  idle_cycles = 0;
   int  hold_cycles = 0;  // forced long sink stall

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic signed [CW-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return -18'sd65536;
         1: return 18'sd65536;
         2: return 18'sd0;
         3: return CW'($urandom);  // full 18-bit pattern, out of range too
         default: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
      endcase
   endfunction

   // monitor: sample at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(elem_type'(req_bus.element_type),
                            kind_type'(req_bus.entity_kind), req_bus.entity_number,
                            req_bus.coord_u, req_bus.coord_v, req_bus.coord_w);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.basis_value, rsp_bus.grad_u, rsp_bus.grad_v,
                              rsp_bus.grad_w, rsp_bus.status);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("quadratic_node_shape_function_eval_top verification failed");
            $finish;
         end
      end
   end

   // sink: random stalls, plus a forced hold-off window
   initial begin
      int g;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (g > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send(logic [2:0] et, logic [1:0] ek, logic [3:0] num,
                       logic signed [CW-1:0] cu, logic signed [CW-1:0] cv,
                       logic signed [CW-1:0] cw, bit with_gap);
      int g;
      g = with_gap ? gap_len() : 0;
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.element_type  <= et;
      req_bus.entity_kind   <= ek;
      req_bus.entity_number <= num;
      req_bus.coord_u       <= cu;
      req_bus.coord_v       <= cv;
      req_bus.coord_w       <= cw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic send_random(bit with_gap);
      logic [2:0] et;
      logic [1:0] ek;
      logic [3:0] num;
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         // mostly legal selections
         et = 3'($urandom_range(0, 4));
         ek = (et == ET_HEX) ? 2'($urandom_range(0, 2)) : EK_EDGE;
         case (et)
            ET_LINE: num = 4'd1;
            ET_TRI:  num = 4'($urandom_range(1, 3));
            ET_QUAD: num = 4'($urandom_range(1, 4));
            ET_TET:  num = 4'($urandom_range(1, 6));
            default: num = (ek == EK_FACE) ? 4'($urandom_range(1, 6))
                                           : 4'($urandom_range(0, 15));
         endcase
         if (et == ET_HEX && ek == EK_EDGE) num = 4'($urandom_range(1, 12));
      end else begin
         et = 3'($urandom);
         ek = 2'($urandom);
         num = 4'($urandom);
      end
      send(et, ek, num, pick_coord(), pick_coord(), pick_coord(), with_gap);
   endtask

   initial begin
      logic signed [CW-1:0] ext[4];
      ext = '{-18'sd65536, 18'sd65536, -18'sd131072, 18'sd131071};
      req_bus.valid = 1'b0;
      req_bus.element_type = '0;
      req_bus.entity_kind = '0;
      req_bus.entity_number = '0;
      req_bus.coord_u = '0;
      req_bus.coord_v = '0;
      req_bus.coord_w = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every status, extremes, out-of-range coordinates
      send(ET_LINE, EK_EDGE, 4'd1, ext[0], ext[3], ext[2], 0);
      send(ET_LINE, EK_EDGE, 4'd0, 18'sd1000, 0, 0, 0);
      send(ET_TRI, EK_EDGE, 4'd3, ext[1], ext[1], 0, 0);
      send(ET_TRI, EK_EDGE, 4'd4, 0, 0, 0, 0);
      send(ET_TRI, EK_FACE, 4'd1, 0, 0, 0, 0);
      send(ET_QUAD, EK_EDGE, 4'd4, ext[2], ext[3], 0, 0);
      send(ET_QUAD, EK_FACE, 4'd1, 0, 0, 0, 0);
      send(ET_TET, EK_EDGE, 4'd6, ext[3], ext[3], ext[3], 0);
      send(ET_TET, EK_EDGE, 4'd1, ext[2], ext[2], ext[2], 0);
      send(ET_TET, EK_FACE, 4'd1, 0, 0, 0, 0);
      send(ET_HEX, EK_EDGE, 4'd12, ext[2], ext[2], ext[2], 0);
      send(ET_HEX, EK_EDGE, 4'd13, 0, 0, 0, 0);
      send(ET_HEX, EK_FACE, 4'd6, ext[3], ext[3], ext[3], 0);
      send(ET_HEX, EK_FACE, 4'd15, 0, 0, 0, 0);
      send(ET_HEX, EK_VOLUME, 4'd9, ext[3], ext[2], ext[3], 0);
      send(ET_HEX, EK_BAD, 4'd1, 0, 0, 0, 0);
      send(ET_PRISM, EK_EDGE, 4'd1, 0, 0, 0, 0);
      send(ET_PYR, EK_FACE, 4'd1, 0, 0, 0, 0);
      send(ET_PRISM, EK_VOLUME, 4'd1, 0, 0, 0, 0);
      send(ET_LINE, EK_VOLUME, 4'd1, 0, 0, 0, 0);
      send(ET_UNK, EK_EDGE, 4'd1, 0, 0, 0, 0);
      send(ET_UNK, EK_BAD, 4'd15, ext[3], ext[2], ext[1], 0);

      // pause until everything is back
      drain();

      // long sink hold-off while the source keeps offering beats
      hold_cycles = 60;
      repeat (40) send_random(0);

      for (int i = 0; i < 1150; i++) begin
         if (i == 600) drain();
         send_random(($urandom_range(0, 3) != 0) && ((i / 150) % 2 == 0));
      end
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0)
         $display("quadratic_node_shape_function_eval_top verification clean");
      else
         $display("quadratic_node_shape_function_eval_top verification failed");
      $finish;
   end
endmodule
